### rtl/gaussian_kernel_generator_top_macros.svh
// assertion helpers shared by the rtl
`ifndef GAUSSIAN_KERNEL_GENERATOR_TOP_MACROS_SVH
`define GAUSSIAN_KERNEL_GENERATOR_TOP_MACROS_SVH

// checked on every edge once out of reset
`define GKG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define GKG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/gkg_pkg.sv
package gkg_pkg;

    // ln 2 in q30
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    // 1.0 in q30 and q1.15
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [15:0] ONE_Q15      = 16'd32768;
    // number of taylor terms after the constant one
    localparam logic [3:0]  SERIES_TERMS = 4'd14;
    // bits of the argument quotient (x below 16.0 in q16)
    localparam int          XDIV_BITS    = 20;
    // bits of the normalising quotient
    localparam int          NDIV_BITS    = 32;

    typedef logic signed [2:0] offset_t;

    // square of a window offset
    function automatic logic [4:0] off_sq(input offset_t v);
        logic [1:0] a;
        a = v[2] ? 2'(-v) : v[1:0];
        return 5'({3'b0, a} * {3'b0, a});
    endfunction

endpackage

### rtl/gaussian_kernel_generator_top.sv
// gaussian kernel generator
// s_ channel: one request word, s_tdata = sigma [15:0] (unsigned q8.8),
//   radius [17:16]; radius above MAX_RADIUS is clamped.
// m_ channel: (2r+1)^2 coefficient words in row-major order, tdata holds the
//   q0.16 coefficient (1.0 saturates to 65535), tlast marks the final word,
//   tuser is set on every word when sigma was zero (coefficients then zero).
// sequencing: one request at a time. the weight pass runs one exponential
//   per offset through setup, argument division, range reduction, 14 taylor
//   terms (each a multiply, then a division by n at 8 bits a cycle), and
//   rounding and write; the centre and offsets where the weight underflows
//   go straight from setup to the write.
//   the output pass reads each weight back from the weight ram through a
//   registered read and divides it by the sum at one bit a cycle.
// s_tready is high only while no request is in progress.
// reset (aresetn low, synchronous) returns to idle and clears the sum; the
//   weight ram is not cleared, every entry is written before its value is used.
// a stall on m_tready holds the current word and halts the block until taken.
`include "gaussian_kernel_generator_top_macros.svh"

module gaussian_kernel_generator_top #(
    parameter int MAX_RADIUS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sigma [15:0], radius [17:16], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // coefficient [15:0]
    output logic        m_tlast,
    output logic        m_tuser    // bad_sigma [0]
);
    import gkg_pkg::*;

    localparam int SIDE  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_START,
        ST_W_XDIV,
        ST_W_KDIV,
        ST_W_MUL,
        ST_W_NDIV,
        ST_W_ROUND,
        ST_W_WRITE,
        ST_N_READ,
        ST_N_LOAD,
        ST_N_DIV,
        ST_N_OUT
    } state_t;

    state_t        st_reg;
    logic [31:0]   s2_reg;
    logic          bad_reg;
    logic [1:0]    rad_reg;
    offset_t       dr_reg, dc_reg;
    logic [AW-1:0] addr_reg;
    logic [23:0]   sum_reg;
    logic [33:0]   rem_reg;
    logic [31:0]   quo_reg;
    logic [4:0]    cnt_reg;
    logic [4:0]    k_reg;
    logic [29:0]   rp_reg;
    logic [30:0]   term_reg;
    logic [31:0]   e_reg;
    logic [3:0]    n_reg;
    logic [3:0]    nrem_reg;
    logic [15:0]   w_reg;
    logic [15:0]   coef_reg;
    logic [15:0]   rd_reg;

    logic [15:0]   wmem [DEPTH];

    // request decode
    logic [1:0] rad_in;
    assign rad_in = (s_tdata[17:16] > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : s_tdata[17:16];

    // window walk
    offset_t rad_s;
    logic    last_off;
    logic [4:0] dsq;
    assign rad_s    = offset_t'({1'b0, rad_reg});
    assign last_off = (dr_reg == rad_s) && (dc_reg == rad_s);
    assign dsq      = off_sq(dr_reg) + off_sq(dc_reg);

    // argument division step
    logic [33:0] x_t;
    logic        x_ge;
    logic [31:0] x_q;
    assign x_t  = {rem_reg[32:0], 1'b0};
    assign x_ge = x_t >= {2'b0, s2_reg};
    assign x_q  = {quo_reg[30:0], x_ge};

    // range reduction step
    logic [33:0] k_cmp;
    logic        k_ge;
    logic [33:0] k_rem;
    assign k_cmp = {4'b0, LN2_Q30} << cnt_reg[2:0];
    assign k_ge  = rem_reg >= k_cmp;
    assign k_rem = k_ge ? rem_reg - k_cmp : rem_reg;

    // taylor product
    logic [60:0] prod;
    assign prod = 61'(term_reg) * 61'(rp_reg);

    // divide by term index, 8 bits a cycle
    logic [31:0] nd_q;
    logic [3:0]  nd_r;
    always_comb begin
        logic [4:0]  r;
        logic [31:0] q;
        r = {1'b0, nrem_reg};
        q = quo_reg;
        for (int j = 0; j < 8; j++) begin
            r = {r[3:0], q[31]};
            q = {q[30:0], 1'b0};
            if (r >= {1'b0, n_reg}) begin
                r    = r - {1'b0, n_reg};
                q[0] = 1'b1;
            end
        end
        nd_q = q;
        nd_r = r[3:0];
    end

    // rounding shift of the series result
    logic [5:0]  sh;
    logic [39:0] rnd_sum;
    logic [39:0] shifted;
    logic [15:0] w_new;
    assign sh      = 6'd16 + {1'b0, k_reg};
    assign rnd_sum = {8'b0, e_reg} + (40'd1 << (sh - 6'd1));
    assign shifted = rnd_sum >> sh;
    assign w_new   = (shifted > 40'(ONE_Q15)) ? ONE_Q15 : shifted[15:0];

    // normalising division step
    logic [24:0] n_t;
    logic        n_ge;
    logic [31:0] n_q;
    assign n_t  = {rem_reg[23:0], quo_reg[31]};
    assign n_ge = n_t >= {1'b0, sum_reg};
    assign n_q  = {quo_reg[30:0], n_ge};

    // weight ram
    always_ff @(posedge aclk) begin
        if (st_reg == ST_W_WRITE) begin
            wmem[addr_reg] <= w_reg;
        end
        rd_reg <= wmem[addr_reg];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            sum_reg <= '0;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        s2_reg   <= 32'(s_tdata[15:0]) * 32'(s_tdata[15:0]);
                        bad_reg  <= (s_tdata[15:0] == 16'd0);
                        rad_reg  <= rad_in;
                        dr_reg   <= -offset_t'({1'b0, rad_in});
                        dc_reg   <= -offset_t'({1'b0, rad_in});
                        addr_reg <= '0;
                        sum_reg  <= '0;
                        st_reg   <= (s_tdata[15:0] == 16'd0) ? ST_N_READ : ST_W_START;
                    end
                end
                ST_W_START: begin
                    if (dsq == 5'd0) begin
                        w_reg  <= ONE_Q15;
                        st_reg <= ST_W_WRITE;
                    end else if (32'({dsq, 11'b0}) >= s2_reg) begin
                        w_reg  <= '0;
                        st_reg <= ST_W_WRITE;
                    end else begin
                        rem_reg <= 34'({dsq, 11'b0});
                        quo_reg <= '0;
                        cnt_reg <= 5'(XDIV_BITS - 1);
                        st_reg  <= ST_W_XDIV;
                    end
                end
                ST_W_XDIV: begin
                    quo_reg <= x_q;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        rem_reg <= {x_q[19:0], 14'b0};
                        k_reg   <= '0;
                        cnt_reg <= 5'd4;
                        st_reg  <= ST_W_KDIV;
                    end else begin
                        rem_reg <= x_ge ? x_t - {2'b0, s2_reg} : x_t;
                    end
                end
                ST_W_KDIV: begin
                    rem_reg <= k_rem;
                    k_reg   <= k_reg | (5'(k_ge) << cnt_reg[2:0]);
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        rp_reg   <= LN2_Q30 - k_rem[29:0];
                        term_reg <= ONE_Q30;
                        e_reg    <= 32'(ONE_Q30);
                        n_reg    <= 4'd1;
                        st_reg   <= ST_W_MUL;
                    end
                end
                ST_W_MUL: begin
                    quo_reg  <= {1'b0, prod[60:30]};
                    nrem_reg <= '0;
                    cnt_reg  <= 5'd3;
                    st_reg   <= ST_W_NDIV;
                end
                ST_W_NDIV: begin
                    quo_reg  <= nd_q;
                    nrem_reg <= nd_r;
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        e_reg    <= e_reg + nd_q;
                        term_reg <= nd_q[30:0];
                        n_reg    <= n_reg + 4'd1;
                        st_reg   <= (n_reg == SERIES_TERMS) ? ST_W_ROUND : ST_W_MUL;
                    end
                end
                ST_W_ROUND: begin
                    w_reg  <= w_new;
                    st_reg <= ST_W_WRITE;
                end
                ST_W_WRITE: begin
                    sum_reg <= sum_reg + 24'(w_reg);
                    if (last_off) begin
                        dr_reg   <= -rad_s;
                        dc_reg   <= -rad_s;
                        addr_reg <= '0;
                        st_reg   <= ST_N_READ;
                    end else begin
                        if (dc_reg == rad_s) begin
                            dc_reg <= -rad_s;
                            dr_reg <= dr_reg + offset_t'(1);
                        end else begin
                            dc_reg <= dc_reg + offset_t'(1);
                        end
                        addr_reg <= addr_reg + AW'(1);
                        st_reg   <= ST_W_START;
                    end
                end
                ST_N_READ: begin
                    st_reg <= ST_N_LOAD;
                end
                ST_N_LOAD: begin
                    if (bad_reg || sum_reg == 24'd0) begin
                        coef_reg <= '0;
                        st_reg   <= ST_N_OUT;
                    end else begin
                        quo_reg <= {rd_reg, 16'b0} + {9'b0, sum_reg[23:1]};
                        rem_reg <= '0;
                        cnt_reg <= 5'(NDIV_BITS - 1);
                        st_reg  <= ST_N_DIV;
                    end
                end
                ST_N_DIV: begin
                    rem_reg <= 34'(n_ge ? n_t - {1'b0, sum_reg} : n_t);
                    quo_reg <= n_q;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        coef_reg <= (n_q > 32'hFFFF) ? 16'hFFFF : n_q[15:0];
                        st_reg   <= ST_N_OUT;
                    end
                end
                ST_N_OUT: begin
                    if (m_tready) begin
                        if (last_off) begin
                            st_reg <= ST_IDLE;
                        end else begin
                            if (dc_reg == rad_s) begin
                                dc_reg <= -rad_s;
                                dr_reg <= dr_reg + offset_t'(1);
                            end else begin
                                dc_reg <= dc_reg + offset_t'(1);
                            end
                            addr_reg <= addr_reg + AW'(1);
                            st_reg   <= ST_N_READ;
                        end
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ports
    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_N_OUT);
    assign m_tdata  = coef_reg;
    assign m_tlast  = last_off;
    assign m_tuser  = bad_reg;

    // checks
    `GKG_ASSERT(a_one_side, !(s_tready && m_tvalid), "request taken while a word is pending")
    `GKG_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "second request accepted")
    `GKG_ASSERT(a_bad_zero, m_tvalid && m_tuser |-> m_tdata == 16'd0, "bad sigma with nonzero word")
    `GKG_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "word presented after reset")

endmodule
